// File: rtl/core/rgq_pkg.sv
// ratio graph query package: default sizes, status codes, controller states
// and the command and status structs between controller and datapath
// no dependencies
package rgq_pkg;

	localparam int VERTICES_DEF  = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VTX_W         = 5;
	localparam int RATIO_W       = 32;
	localparam int IN_DATA_W     = 48;

	typedef enum logic [1:0] {
		ST_STORED   = 2'd0,
		ST_ANSWERED = 2'd1,
		ST_NOPATH   = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_WR_R,
		DP_DIV_STEP,
		DP_WR_RECIP,
		DP_DFS_INIT,
		DP_SCAN_RD,
		DP_SCAN_NEXT,
		DP_PUSH,
		DP_POP,
		DP_PROD_RD,
		DP_PROD_MUL,
		DP_PROD_ACC,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_WR_RECIP,
		S_DFS_INIT,
		S_SCAN_RD,
		S_SCAN_CHECK,
		S_SELF_CHECK,
		S_PROD_RD,
		S_PROD_MUL,
		S_PROD_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mode;
		logic ratio_zero;
		logic in_range;
		logic a_eq_b;
		logic div_last;
		logic hit;
		logic rd_nz;
		logic scan_zero;
		logic stack_full;
		logic cand_dst;
		logic top_one;
		logic prod_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/ratio_graph_query.sv
// ratio graph query top level: input and result streams around the
// controller and datapath; depends on rgq_pkg, rgq_ctrl, rgq_datapath
//
// usage: each input transfer carries s_tuser = mode (store or query) and
// s_tdata = first vertex, second vertex, signed fixed-point ratio. Every
// input transfer yields exactly one result transfer: m_tdata is the
// quotient, m_tuser the status (stored, answered, no path, zero ratio).
// One item is handled at a time; s_tready is high only while idle.
// A store runs the one-bit-per-cycle reciprocal divider and writes the
// ratio and its reciprocal. A query reads ratios during the search and
// then one ratio per edge of the found path for the product; the single
// read port of the ratio matrix memory serialises these reads.
// After reset the matrix is swept to zero with s_tready low. The result
// sits in an output register: the next item is accepted while it waits,
// and a later result holds in the controller until m_tready frees the
// register.
module ratio_graph_query import rgq_pkg::*; #(
	parameter int VERTICES  = VERTICES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // first_vertex, second_vertex, ratio, zero pad
	input  logic                 s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [RATIO_W-1:0]   m_tdata,  // quotient
	output logic [1:0]           m_tuser   // status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rgq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rgq_datapath #(
		.VERTICES  (VERTICES),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_mode      (s_tuser),
		.in_first     (s_tdata[4:0]),
		.in_second    (s_tdata[9:5]),
		.in_ratio     (s_tdata[41:10]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_quotient (m_tdata),
		.out_status   (m_tuser)
	);

endmodule

// File: rtl/core/rgq_datapath.sv
// ratio graph query datapath: ratio matrix memory, search stack, visited marks,
// reciprocal divider, path product multiplier and result register
// depends on rgq_pkg
module rgq_datapath import rgq_pkg::*; #(
	parameter int VERTICES  = VERTICES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 in_mode,
	input  logic [VTX_W-1:0]     in_first,
	input  logic [VTX_W-1:0]     in_second,
	input  logic [RATIO_W-1:0]   in_ratio,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RATIO_W-1:0]   out_quotient,
	output logic [1:0]           out_status
);

	localparam int VW    = $clog2(VERTICES);
	localparam int TW    = VW + 1;
	localparam int DEPTH = VERTICES * VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = (2 * FRAC_BITS + 1 > 33) ? 2 * FRAC_BITS + 1 : 33;
	localparam int CW    = $clog2(QW + 1);
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;
	localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;
	localparam logic [RATIO_W-1:0] ONE = 32'd1 << FRAC_BITS;

	logic [RATIO_W-1:0] mem [DEPTH];
	logic [RATIO_W-1:0] rd_data_q;
	logic               mode_q;
	logic [6:0]         a_q, b_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [AW-1:0]      clr_q;
	logic [VERTICES-1:0] visited_q;
	logic [VW-1:0]      stack_q [VERTICES];
	logic [TW-1:0]      top_q;
	logic [VW-1:0]      scan_q;
	logic [VW-1:0]      k_q;
	logic signed [RATIO_W-1:0] p_q;
	logic signed [63:0] mul_s1;
	logic [31:0]        rem_q;
	logic [QW-1:0]      quo_q, num_q;
	logic [CW-1:0]      cnt_q;
	logic               out_valid_q;
	logic [RATIO_W-1:0] out_q_q;
	logic [1:0]         out_st_q;

	logic [VW-1:0]      a_idx, b_idx, top_row, k_row, k1_row, rd_row, rd_col;
	logic [TW-1:0]      top_m1;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [RATIO_W-1:0] wr_data;
	logic               we, re;
	logic               neg;
	logic [31:0]        dvs;
	logic [32:0]        rem_sh, diff;
	logic               ge;
	logic [RATIO_W-1:0] recip;
	logic signed [63:0] prod_c, biased, scaled;
	logic signed [RATIO_W-1:0] sat_p;
	logic               hit;

	assign a_idx   = a_q[VW-1:0];
	assign b_idx   = b_q[VW-1:0];
	assign top_m1  = top_q - TW'(1);
	assign top_row = stack_q[top_m1[VW-1:0]];
	assign k_row   = stack_q[k_q];
	assign k1_row  = stack_q[k_q + VW'(1)];
	assign hit     = (rd_data_q != '0) && !visited_q[scan_q];

	// divider
	assign neg    = ratio_q[RATIO_W-1];
	assign dvs    = neg ? (~ratio_q + 32'd1) : ratio_q;
	assign rem_sh = {rem_q, num_q[QW-1]};
	assign diff   = rem_sh - {1'b0, dvs};
	assign ge     = rem_sh >= {1'b0, dvs};

	always_comb begin
		if (!neg) begin
			recip = (quo_q > QW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : quo_q[31:0];
		end else begin
			recip = (quo_q > QW'(33'h080000000)) ? 32'h80000000 : (~quo_q[31:0] + 32'd1);
		end
	end

	// product scaling with truncation toward zero and saturation
	assign prod_c = p_q * $signed(rd_data_q);
	assign biased = mul_s1[63] ? (mul_s1 + $signed(BIAS)) : mul_s1;
	assign scaled = biased >>> FRAC_BITS;
	always_comb begin
		if (scaled > MAXV) begin
			sat_p = 32'sh7FFFFFFF;
		end else if (scaled < MINV) begin
			sat_p = 32'sh80000000;
		end else begin
			sat_p = scaled[31:0];
		end
	end

	// memory port selection
	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_row  = top_row;
		rd_col  = scan_q;
		unique case (cmd.op)
			DP_CLEAR: begin
				we = 1'b1;
			end
			DP_WR_R: begin
				we      = 1'b1;
				wr_addr = AW'(a_idx) * AW'(VERTICES) + AW'(b_idx);
				wr_data = ratio_q;
			end
			DP_WR_RECIP: begin
				we      = 1'b1;
				wr_addr = AW'(b_idx) * AW'(VERTICES) + AW'(a_idx);
				wr_data = recip;
			end
			DP_SCAN_RD: begin
				re = 1'b1;
			end
			DP_PROD_RD: begin
				re     = 1'b1;
				rd_row = k_row;
				rd_col = k1_row;
			end
			default: begin
			end
		endcase
	end
	assign rd_addr = AW'(rd_row) * AW'(VERTICES) + AW'(rd_col);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				mode_q  <= in_mode;
				a_q     <= {2'b00, in_first};
				b_q     <= {2'b00, in_second};
				ratio_q <= in_ratio;
			end
			DP_WR_R: begin
				rem_q <= '0;
				quo_q <= '0;
				num_q <= QW'(1) << (2 * FRAC_BITS);
			end
			DP_DIV_STEP: begin
				rem_q <= ge ? diff[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[QW-2:0], ge};
				num_q <= num_q << 1;
			end
			DP_DFS_INIT: begin
				p_q        <= ONE;
				k_q        <= '0;
				stack_q[0] <= a_idx;
			end
			DP_PUSH: begin
				stack_q[top_q[VW-1:0]] <= scan_q;
			end
			DP_PROD_MUL: begin
				mul_s1 <= prod_c;
			end
			DP_PROD_ACC: begin
				p_q <= sat_p;
				k_q <= k_q + VW'(1);
			end
			DP_OUT: begin
				out_q_q  <= (cmd.out_status == ST_ANSWERED) ? p_q : '0;
				out_st_q <= cmd.out_status;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			visited_q   <= '0;
			top_q       <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				DP_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				DP_WR_R: begin
					cnt_q <= '0;
				end
				DP_DIV_STEP: begin
					cnt_q <= cnt_q + CW'(1);
				end
				DP_DFS_INIT: begin
					visited_q <= VERTICES'(1) << a_idx;
					top_q     <= TW'(1);
					scan_q    <= VW'(VERTICES - 1);
				end
				DP_SCAN_NEXT: begin
					scan_q <= scan_q - VW'(1);
				end
				DP_PUSH: begin
					visited_q[scan_q] <= 1'b1;
					top_q             <= top_q + TW'(1);
					scan_q            <= VW'(VERTICES - 1);
				end
				DP_POP: begin
					if (hit) begin
						visited_q[scan_q] <= 1'b1;
					end
					top_q  <= top_m1;
					scan_q <= VW'(VERTICES - 1);
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.clr_last   = clr_q == AW'(DEPTH - 1);
	assign stat.mode       = mode_q;
	assign stat.ratio_zero = ratio_q == '0;
	assign stat.in_range   = (a_q < 7'(VERTICES)) && (b_q < 7'(VERTICES));
	assign stat.a_eq_b     = a_q == b_q;
	assign stat.div_last   = cnt_q == CW'(QW - 1);
	assign stat.hit        = hit;
	assign stat.rd_nz      = rd_data_q != '0;
	assign stat.scan_zero  = scan_q == '0;
	assign stat.stack_full = top_q == TW'(VERTICES);
	assign stat.cand_dst   = scan_q == b_idx;
	assign stat.top_one    = top_q == TW'(1);
	assign stat.prod_last  = ({1'b0, k_q} + TW'(2)) >= top_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_quotient = out_q_q;
	assign out_status   = out_st_q;

endmodule

// File: rtl/core/rgq_ctrl.sv
// ratio graph query controller: sequences clearing, store, search and product
// depends on rgq_pkg
module rgq_ctrl import rgq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= ST_STORED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd.op         = DP_NOP;
		cmd.out_status = res_q;
		in_ready       = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = DP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (!stat.mode) begin
					priority if (stat.ratio_zero) begin
						res_d   = ST_ZERO;
						state_d = S_DONE;
					end else if (!stat.in_range) begin
						res_d   = ST_STORED;
						state_d = S_DONE;
					end else begin
						cmd.op  = DP_WR_R;
						state_d = S_DIV;
					end
				end else if (!stat.in_range) begin
					res_d   = ST_NOPATH;
					state_d = S_DONE;
				end else begin
					state_d = S_DFS_INIT;
				end
			end
			S_DIV: begin
				cmd.op = DP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_WR_RECIP;
				end
			end
			S_WR_RECIP: begin
				cmd.op  = DP_WR_RECIP;
				res_d   = ST_STORED;
				state_d = S_DONE;
			end
			S_DFS_INIT: begin
				cmd.op  = DP_DFS_INIT;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.op  = DP_SCAN_RD;
				state_d = stat.a_eq_b ? S_SELF_CHECK : S_SCAN_CHECK;
			end
			S_SELF_CHECK: begin
				priority if (stat.rd_nz) begin
					res_d   = ST_ANSWERED;
					state_d = S_DONE;
				end else if (stat.scan_zero) begin
					res_d   = ST_NOPATH;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_CHECK: begin
				priority if (stat.hit && !stat.stack_full) begin
					cmd.op  = DP_PUSH;
					state_d = stat.cand_dst ? S_PROD_RD : S_SCAN_RD;
				end else if (stat.hit || stat.scan_zero) begin
					cmd.op = DP_POP;
					if (stat.top_one) begin
						res_d   = ST_NOPATH;
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN_RD;
					end
				end else begin
					cmd.op  = DP_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_PROD_RD: begin
				cmd.op  = DP_PROD_RD;
				state_d = S_PROD_MUL;
			end
			S_PROD_MUL: begin
				cmd.op  = DP_PROD_MUL;
				state_d = S_PROD_ACC;
			end
			S_PROD_ACC: begin
				cmd.op = DP_PROD_ACC;
				if (stat.prod_last) begin
					res_d   = ST_ANSWERED;
					state_d = S_DONE;
				end else begin
					state_d = S_PROD_RD;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
